[design/thac_pkg.sv]
package thac_pkg;

    localparam int RAW_W       = 16;
    localparam int TEMP_MAG_W  = 14;
    localparam int HUM_CENTI_W = 15;
    localparam int TEMP_PROD_W = 31;
    localparam int TEMP_X_W    = 32;

    // centi-degrees: 175.72 * avg / 65536 - 46.85
    localparam logic [14:0]          TEMP_SCALE  = 15'd17572;
    localparam logic [TEMP_X_W-1:0]  TEMP_OFFSET = 32'd307036160;   // 4685 << 16

    // centi-percent: floor(avg * 0.1907) - 600, via a scaled reciprocal
    localparam int                   HUM_SHIFT   = 30;
    localparam int                   HUM_MUL_W   = 28;
    localparam logic [HUM_MUL_W-1:0] HUM_MUL     =
        HUM_MUL_W'(((64'd1907 << HUM_SHIFT) + 64'd9999) / 64'd10000);
    localparam int                   HUM_Q_W     = 14;
    localparam logic [HUM_CENTI_W-1:0] HUM_OFFSET = 15'd600;

    typedef struct packed {
        logic [HUM_CENTI_W-1:0] hum_centi;
        logic                   temp_below_zero;
        logic [TEMP_MAG_W-1:0]  temp_magnitude_centi;
        logic [RAW_W-1:0]       avg_hum_raw;
        logic [RAW_W-1:0]       avg_temp_raw;
    } result_t;

endpackage

[design/temp_humidity_average_convert.sv]
// channel  | beat fields (tdata, lowest bit first)                        | width
// s_axis   | temp_raw[15:0], hum_raw[31:16]                               | 32
// m_axis   | avg_temp_raw[15:0], avg_hum_raw[31:16], temp_magnitude_centi | 64
//          | [45:32], temp_below_zero[46], hum_centi[61:47], zero pad     |
//
// one beat in and one beat out per cycle unless m_axis_tready stalls the output; a result
// passes the window update, reciprocal divide, constant multiply and offset registers in turn
// two of the stages are multiplier stages, each stage holds one multiply per field
// reset clears both rings, the running sums, the slot pointer and all stage valids
// stalls ripple back stage by stage, so empty stages keep taking beats
module temp_humidity_average_convert
    import thac_pkg::*;
#(
    parameter int WINDOW_LEN = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // temp_raw, hum_raw
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // avg_temp_raw, avg_hum_raw, temp_magnitude_centi,
                                        // temp_below_zero, hum_centi, pad
);

    localparam int SLOT_W     = $clog2(WINDOW_LEN);
    localparam int SUM_W      = RAW_W + $clog2(WINDOW_LEN);
    localparam int AVG_SHIFT  = SUM_W + $clog2(WINDOW_LEN);
    localparam int AVG_PROD_W = 2 * SUM_W + 1;
    localparam logic [SUM_W:0] AVG_MUL =
        (SUM_W+1)'(((64'd1 << AVG_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

    // window state
    logic [RAW_W-1:0]  temp_win_reg [WINDOW_LEN];
    logic [RAW_W-1:0]  hum_win_reg  [WINDOW_LEN];
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SUM_W-1:0]  temp_sum_reg, temp_sum_next;
    logic [SUM_W-1:0]  hum_sum_reg, hum_sum_next;

    // pipeline
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              rdy1, rdy2, rdy3, rdy4;
    logic [SUM_W-1:0]  tsum1_reg, hsum1_reg;
    logic [RAW_W-1:0]  avg_t2_reg, avg_h2_reg, avg_t2_next, avg_h2_next;
    logic [RAW_W-1:0]  avg_t3_reg, avg_h3_reg;
    logic [TEMP_PROD_W-1:0] tprod3_reg;
    logic [HUM_Q_W-1:0]     hq3_reg, hq3_next;
    result_t           out_reg, out_next;

    logic [RAW_W-1:0]  temp_raw, hum_raw;
    logic              s_accept;
    logic [AVG_PROD_W-1:0] avg_t_prod, avg_h_prod;
    logic [RAW_W+HUM_MUL_W-1:0] hum_prod;
    logic signed [TEMP_X_W-1:0] temp_x, temp_abs;

    assign temp_raw = s_axis_tdata[15:0];
    assign hum_raw  = s_axis_tdata[31:16];

    assign rdy4 = !v4_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;
    assign s_accept = s_axis_tvalid && rdy1;

    // running sums: drop the slot being overwritten, add the new sample
    always_comb begin
        temp_sum_next = temp_sum_reg - SUM_W'(temp_win_reg[slot_reg]) + SUM_W'(temp_raw);
        hum_sum_next  = hum_sum_reg - SUM_W'(hum_win_reg[slot_reg]) + SUM_W'(hum_raw);
        slot_next     = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                temp_win_reg[i] <= '0;
                hum_win_reg[i]  <= '0;
            end
            slot_reg     <= '0;
            temp_sum_reg <= '0;
            hum_sum_reg  <= '0;
        end else if (s_accept) begin
            temp_win_reg[slot_reg] <= temp_raw;
            hum_win_reg[slot_reg]  <= hum_raw;
            slot_reg     <= slot_next;
            temp_sum_reg <= temp_sum_next;
            hum_sum_reg  <= hum_sum_next;
        end
    end

    // exact floor(sum / WINDOW_LEN) by reciprocal multiply
    always_comb begin
        avg_t_prod  = AVG_PROD_W'(tsum1_reg) * AVG_PROD_W'(AVG_MUL);
        avg_h_prod  = AVG_PROD_W'(hsum1_reg) * AVG_PROD_W'(AVG_MUL);
        avg_t2_next = avg_t_prod[AVG_SHIFT +: RAW_W];
        avg_h2_next = avg_h_prod[AVG_SHIFT +: RAW_W];
    end

    always_comb begin
        hum_prod = (RAW_W+HUM_MUL_W)'(avg_h2_reg) * (RAW_W+HUM_MUL_W)'(HUM_MUL);
        hq3_next = hum_prod[HUM_SHIFT +: HUM_Q_W];
    end

    always_comb begin
        temp_x   = $signed({1'b0, tprod3_reg}) - $signed(TEMP_OFFSET);
        temp_abs = temp_x[TEMP_X_W-1] ? -temp_x : temp_x;
        out_next.avg_temp_raw         = avg_t3_reg;
        out_next.avg_hum_raw          = avg_h3_reg;
        out_next.temp_magnitude_centi = temp_abs[16 +: TEMP_MAG_W];
        out_next.temp_below_zero      = temp_x[TEMP_X_W-1];
        out_next.hum_centi            = {1'b0, hq3_reg} - HUM_OFFSET;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tsum1_reg <= temp_sum_next;
            hsum1_reg <= hum_sum_next;
        end
        if (rdy2 && v1_reg) begin
            avg_t2_reg <= avg_t2_next;
            avg_h2_reg <= avg_h2_next;
        end
        if (rdy3 && v2_reg) begin
            avg_t3_reg <= avg_t2_reg;
            avg_h3_reg <= avg_h2_reg;
            tprod3_reg <= TEMP_PROD_W'(avg_t2_reg) * TEMP_PROD_W'(TEMP_SCALE);
            hq3_reg    <= hq3_next;
        end
        if (rdy4 && v3_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {2'b00, out_reg};

    // ring pointer never leaves the window
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= LAST_SLOT)
        else $error("write slot out of range");

    a_slot_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && slot_reg == LAST_SLOT) |=> slot_reg == '0)
        else $error("write slot failed to wrap");

    a_held_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !m_axis_tready) |=> (v4_reg && $stable(out_reg)))
        else $error("stalled result lost or changed");

    // negative temperature exactly when the average is below the zero point
    a_sign_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (out_reg.temp_below_zero == (out_reg.avg_temp_raw <= 16'd17473)))
        else $error("below-zero flag disagrees with average");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> v1_reg)
        else $error("accepted beat not in first stage");

endmodule
